/* hdl/timer_bank_expiry_sweep_unit_assert.svh */
// Assertion macros shared by the timer bank checker.
`ifndef TIMER_BANK_EXPIRY_SWEEP_UNIT_ASSERT_SVH
`define TIMER_BANK_EXPIRY_SWEEP_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TBES_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TBES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tbes_pkg.sv */
// Shared constants, types and command/status structs of the timer bank.
package tbes_pkg;

  localparam int unsigned NUM_TIMERS = 16;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PERIOD_W   = 31;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_SWEEP = 2'd2;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic exec;         // start, stop or unknown op command
    logic sweep_begin;  // latch now, reset scan counter
    logic scan;         // read entry at counter, advance
    logic flush;        // emit final sweep result
  } ctl_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } dp_status_t;

endpackage

/* hdl/tbes_ctrl.sv */
// Controller state machine of the timer bank sweep.
module tbes_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          operation,
  input  tbes_pkg::dp_status_t dp_st,
  output tbes_pkg::ctl_cmd_t  cmd,
  output logic                busy
);

  tbes_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      tbes_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation == tbes_pkg::OP_SWEEP) begin
            cmd.sweep_begin = 1'b1;
            state_next      = tbes_pkg::ST_SCAN;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      tbes_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (dp_st.cnt_last) begin
          state_next = tbes_pkg::ST_DRAIN;
        end
      end
      tbes_pkg::ST_DRAIN: begin
        state_next = tbes_pkg::ST_FLUSH;
      end
      tbes_pkg::ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = tbes_pkg::ST_IDLE;
      end
      default: begin
        state_next = tbes_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/tbes_datapath.sv */
// Timer storage, two-stage expiry check and result register of the timer bank.
module tbes_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tbes_pkg::ctl_cmd_t                   cmd,
  input  logic [1:0]                           operation,
  input  logic [tbes_pkg::IDX_W-1:0]           timer_index,
  input  logic [tbes_pkg::PERIOD_W-1:0]        period,
  input  logic                                 one_shot,
  input  logic [tbes_pkg::TIME_W-1:0]          now,
  output tbes_pkg::dp_status_t                 dp_st,
  output logic                                 strobe,
  output logic [1:0]                           kind,
  output logic [tbes_pkg::IDX_W-1:0]           expired_index,
  output logic                                 status,
  output logic                                 last
);

  logic [tbes_pkg::NUM_TIMERS-1:0] armed;
  logic [tbes_pkg::NUM_TIMERS-1:0] single_fire;
  logic [tbes_pkg::TIME_W-1:0]     base_time    [tbes_pkg::NUM_TIMERS];
  logic [tbes_pkg::PERIOD_W-1:0]   timer_period [tbes_pkg::NUM_TIMERS];

  logic [tbes_pkg::TIME_W-1:0]   now_q;
  logic [tbes_pkg::IDX_W-1:0]    cnt;

  // evaluate stage
  logic                          ev_valid;
  logic [tbes_pkg::IDX_W-1:0]    ev_idx;
  logic [tbes_pkg::TIME_W-1:0]   ev_elapsed;
  logic [tbes_pkg::TIME_W-1:0]   ev_base;
  logic [tbes_pkg::PERIOD_W-1:0] ev_period;
  logic                          ev_armed;
  logic                          ev_once;

  logic                          pend_valid;
  logic [tbes_pkg::IDX_W-1:0]    pend_idx;

  logic                          in_range;
  logic                          do_start;
  logic                          reached;
  logic                          behind;
  logic                          fire;
  logic [tbes_pkg::TIME_W-1:0]   base_adv;

  logic                          emit;
  logic [1:0]                    emit_kind;
  logic [tbes_pkg::IDX_W-1:0]    emit_idx;
  logic                          emit_status;
  logic                          emit_last;

  assign in_range = 32'(timer_index) < tbes_pkg::NUM_TIMERS;
  assign do_start = cmd.exec && (operation == tbes_pkg::OP_START) &&
                    (period != '0) && in_range;

  // signed elapsed >= period; catch-up when elapsed > 2 * period
  assign reached  = $signed(ev_elapsed) >= $signed({1'b0, ev_period});
  assign behind   = $signed({ev_elapsed[tbes_pkg::TIME_W-1], ev_elapsed}) >
                    $signed({1'b0, ev_period, 1'b0});
  assign fire     = ev_valid && ev_armed && reached;
  assign base_adv = ev_base + {1'b0, ev_period};

  assign dp_st.cnt_last = (cnt == tbes_pkg::IDX_W'(tbes_pkg::NUM_TIMERS - 1));

  always_comb begin
    emit        = 1'b0;
    emit_kind   = tbes_pkg::KIND_ACK;
    emit_idx    = '0;
    emit_status = tbes_pkg::STATUS_OK;
    emit_last   = 1'b1;
    if (cmd.exec) begin
      emit = 1'b1;
      if ((operation == tbes_pkg::OP_START) && (period == '0)) begin
        emit_status = tbes_pkg::STATUS_REFUSED;
      end
    end
    if (fire && pend_valid) begin
      emit      = 1'b1;
      emit_kind = tbes_pkg::KIND_EXPIRED;
      emit_idx  = pend_idx;
      emit_last = 1'b0;
    end
    if (cmd.flush) begin
      emit = 1'b1;
      if (pend_valid) begin
        emit_kind = tbes_pkg::KIND_EXPIRED;
        emit_idx  = pend_idx;
      end else begin
        emit_kind = tbes_pkg::KIND_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= '0;
      single_fire <= '0;
      cnt         <= '0;
      ev_valid    <= 1'b0;
      pend_valid  <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      ev_valid <= cmd.scan;
      strobe   <= emit;
      if (do_start) begin
        armed[timer_index]       <= 1'b1;
        single_fire[timer_index] <= one_shot;
      end
      if (cmd.exec && (operation == tbes_pkg::OP_STOP) && in_range) begin
        armed[timer_index] <= 1'b0;
      end
      if (cmd.sweep_begin) begin
        cnt        <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.scan) begin
        cnt <= cnt + 1'b1;
      end
      if (fire) begin
        pend_valid <= 1'b1;
        if (ev_once) begin
          armed[ev_idx] <= 1'b0;
        end
      end
      if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start) begin
      base_time[timer_index]    <= now;
      timer_period[timer_index] <= period;
    end
    if (fire && !ev_once) begin
      base_time[ev_idx] <= behind ? now_q : base_adv;
    end
    if (cmd.sweep_begin) begin
      now_q <= now;
    end
    if (cmd.scan) begin
      ev_idx     <= cnt;
      ev_base    <= base_time[cnt];
      ev_elapsed <= now_q - base_time[cnt];
      ev_period  <= timer_period[cnt];
      ev_armed   <= armed[cnt];
      ev_once    <= single_fire[cnt];
    end
    if (fire) begin
      pend_idx <= ev_idx;
    end
    kind          <= emit_kind;
    expired_index <= emit_idx;
    status        <= emit_status;
    last          <= emit_last;
  end

endmodule

/* hdl/timer_bank_expiry_sweep_unit.sv */
// Top level of the timer bank with expiry sweep.
//
//   channel   handshake            payload
//   command   start / busy         operation, timer_index, period, one_shot, now
//   result    strobe (one cycle)   kind, expired_index, status, last
//
// Start, stop and unknown commands acknowledge on the next cycle, while a new command may
// already transfer. A sweep keeps busy high after its transfer while it reads and evaluates
// the timers, drains and gives the final result. An expiry is held until the next one or the
// final result; the last result shows in the first cycle after busy falls, when a new sweep
// may already transfer.
// rst is synchronous and disarms all timers, not periods or base times; results never stall.
module timer_bank_expiry_sweep_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [tbes_pkg::IDX_W-1:0]    timer_index,
  input  logic [tbes_pkg::PERIOD_W-1:0] period,
  input  logic                          one_shot,
  input  logic [tbes_pkg::TIME_W-1:0]   now,
  output logic                          strobe,
  output logic [1:0]                    kind,
  output logic [tbes_pkg::IDX_W-1:0]    expired_index,
  output logic                          status,
  output logic                          last
);

  tbes_pkg::ctl_cmd_t   cmd;
  tbes_pkg::dp_status_t dp_st;

  tbes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .dp_st     (dp_st),
    .cmd       (cmd),
    .busy      (busy)
  );

  tbes_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (operation),
    .timer_index   (timer_index),
    .period        (period),
    .one_shot      (one_shot),
    .now           (now),
    .dp_st         (dp_st),
    .strobe        (strobe),
    .kind          (kind),
    .expired_index (expired_index),
    .status        (status),
    .last          (last)
  );

endmodule

/* hdl/tbes_checker.sv */
// Port-level checker of the timer bank and its bind to the top level.
`include "timer_bank_expiry_sweep_unit_assert.svh"

module tbes_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    operation,
  input logic                          strobe,
  input logic [1:0]                    kind,
  input logic [tbes_pkg::IDX_W-1:0]    expired_index,
  input logic                          status,
  input logic                          last
);

  `TBES_ASSERT_NEXT(a_cmd_ack, start && !busy && (operation != tbes_pkg::OP_SWEEP), strobe && (kind == tbes_pkg::KIND_ACK) && last, "command transfer not acknowledged next cycle")
  `TBES_ASSERT_NEXT(a_sweep_busy, start && !busy && (operation == tbes_pkg::OP_SWEEP), busy, "sweep transfer did not raise busy")
  `TBES_ASSERT_NOW(a_single_last, strobe && (kind != tbes_pkg::KIND_EXPIRED), last && (expired_index == '0), "non-expiry result not final or has index")
  `TBES_ASSERT_NOW(a_refused_ack, strobe && (status == tbes_pkg::STATUS_REFUSED), kind == tbes_pkg::KIND_ACK, "refused status on a non-acknowledge result")

endmodule

bind timer_bank_expiry_sweep_unit tbes_checker u_tbes_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .operation     (operation),
  .strobe        (strobe),
  .kind          (kind),
  .expired_index (expired_index),
  .status        (status),
  .last          (last)
);

/* test/timer_bank_expiry_checker.sv */
`timescale 1ns / 1ps
// Checker for the timer bank: predicts results of each command transfer and compares them.
module timer_bank_expiry_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [tbes_pkg::IDX_W-1:0]    timer_index,
  input  logic [tbes_pkg::PERIOD_W-1:0] period,
  input  logic                          one_shot,
  input  logic [tbes_pkg::TIME_W-1:0]   now,
  input  logic                          strobe,
  input  logic [1:0]                    kind,
  input  logic [tbes_pkg::IDX_W-1:0]    expired_index,
  input  logic                          status,
  input  logic                          last,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [1:0]                 kind;
    logic [tbes_pkg::IDX_W-1:0] idx;
    logic                       status;
    logic                       last;
  } timer_result_t;

  timer_result_t expected_results[$];

  logic                          armed_q    [tbes_pkg::NUM_TIMERS];
  logic                          one_shot_q [tbes_pkg::NUM_TIMERS];
  logic [tbes_pkg::TIME_W-1:0]   base_q     [tbes_pkg::NUM_TIMERS];
  logic [tbes_pkg::PERIOD_W-1:0] period_q   [tbes_pkg::NUM_TIMERS];

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void push_result(input logic [1:0] k,
                                      input logic [tbes_pkg::IDX_W-1:0] i,
                                      input logic s, input logic l);
    timer_result_t r;
    r.kind   = k;
    r.idx    = i;
    r.status = s;
    r.last   = l;
    expected_results = {expected_results, r};
  endfunction

  function automatic void predict_expiries(input logic [1:0] op,
                                           input logic [tbes_pkg::IDX_W-1:0] idx,
                                           input logic [tbes_pkg::PERIOD_W-1:0] per,
                                           input logic once,
                                           input logic [tbes_pkg::TIME_W-1:0] t);
    logic [tbes_pkg::IDX_W-1:0]         hits[$];
    logic signed [tbes_pkg::TIME_W-1:0] gap;
    logic signed [tbes_pkg::TIME_W-1:0] lim;
    case (op)
      tbes_pkg::OP_START: begin
        if (per == '0) begin
          push_result(tbes_pkg::KIND_ACK, '0, tbes_pkg::STATUS_REFUSED, 1'b1);
        end else begin
          period_q[idx]   = per;
          one_shot_q[idx] = once;
          base_q[idx]     = t;
          armed_q[idx]    = 1'b1;
          push_result(tbes_pkg::KIND_ACK, '0, tbes_pkg::STATUS_OK, 1'b1);
        end
      end
      tbes_pkg::OP_STOP: begin
        armed_q[idx] = 1'b0;
        push_result(tbes_pkg::KIND_ACK, '0, tbes_pkg::STATUS_OK, 1'b1);
      end
      tbes_pkg::OP_SWEEP: begin
        for (int i = 0; i < tbes_pkg::NUM_TIMERS; i++) begin
          if (armed_q[i]) begin
            lim = $signed({1'b0, period_q[i]});
            gap = $signed(t - base_q[i]);
            if (gap >= lim) begin
              if (one_shot_q[i]) begin
                armed_q[i] = 1'b0;
              end else begin
                base_q[i] = base_q[i] + tbes_pkg::TIME_W'(period_q[i]);
                gap = $signed(t - base_q[i]);
                // still more than one period behind: catch up to now
                if (gap > lim) base_q[i] = t;
              end
              hits = {hits, tbes_pkg::IDX_W'(i)};
            end
          end
        end
        if (hits.size() == 0) begin
          push_result(tbes_pkg::KIND_NONE, '0, tbes_pkg::STATUS_OK, 1'b1);
        end else begin
          foreach (hits[k])
            push_result(tbes_pkg::KIND_EXPIRED, hits[k], tbes_pkg::STATUS_OK,
                        k == hits.size() - 1);
        end
      end
      default: begin
        push_result(tbes_pkg::KIND_ACK, '0, tbes_pkg::STATUS_OK, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (rst) begin
      expected_results.delete();
      for (int i = 0; i < tbes_pkg::NUM_TIMERS; i++) begin
        armed_q[i]    = 1'b0;
        one_shot_q[i] = 1'b0;
      end
      pending <= 0;
    end else begin
      if (strobe) begin
        got.kind   = kind;
        got.idx    = expired_index;
        got.status = status;
        got.last   = last;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d idx=%0d status=%0d last=%0d",
                                    kind, expired_index, status, last));
        end else begin
          want = expected_results.pop_front();
          if (got !== want)
            report_mismatch($sformatf("kind %0d/%0d idx %0d/%0d status %0d/%0d last %0d/%0d",
                                      got.kind, want.kind, got.idx, want.idx,
                                      got.status, want.status, got.last, want.last));
        end
      end
      if (start && !busy) predict_expiries(operation, timer_index, period, one_shot, now);
      pending <= expected_results.size();
    end
  end

endmodule

/* test/tb_timer_bank_expiry_sweep_unit.sv */
`timescale 1ns / 1ps
// Testbench top: drives timer commands and sweeps into the timer bank and reports the verdict.
module tb_timer_bank_expiry_sweep_unit;

  localparam logic [1:0] OP_UNKNOWN   = 2'd3;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         PHASE_ITEMS  = 49;

  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          start       = 1'b0;
  logic [1:0]                    operation   = '0;
  logic [tbes_pkg::IDX_W-1:0]    timer_index = '0;
  logic [tbes_pkg::PERIOD_W-1:0] period      = '0;
  logic                          one_shot    = 1'b0;
  logic [tbes_pkg::TIME_W-1:0]   now         = '0;
  logic                          busy;
  logic                          strobe;
  logic [1:0]                    kind;
  logic [tbes_pkg::IDX_W-1:0]    expired_index;
  logic                          status;
  logic                          last;

  int                            mismatches;
  int                            outstanding;
  int                            idle_pct = 0;
  logic [tbes_pkg::TIME_W-1:0]   sweep_time = '0;
  int                            idle_by_phase[4] = '{0, 80, 31, 0};

  always #4 clk = ~clk;

  timer_bank_expiry_sweep_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .timer_index(timer_index), .period(period),
    .one_shot(one_shot), .now(now),
    .strobe(strobe), .kind(kind), .expired_index(expired_index),
    .status(status), .last(last)
  );

  timer_bank_expiry_checker u_expiry_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .timer_index(timer_index), .period(period),
    .one_shot(one_shot), .now(now),
    .strobe(strobe), .kind(kind), .expired_index(expired_index),
    .status(status), .last(last),
    .fail_count(mismatches), .pending(outstanding)
  );

  task automatic idle_cycle();
    start       <= 1'b0;
    operation   <= 2'($urandom);
    timer_index <= tbes_pkg::IDX_W'($urandom);
    period      <= tbes_pkg::PERIOD_W'($urandom);
    one_shot    <= 1'($urandom);
    now         <= $urandom;
    @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_cmd(input logic [1:0] op, input logic [tbes_pkg::IDX_W-1:0] idx,
                          input logic [tbes_pkg::PERIOD_W-1:0] per, input logic once,
                          input logic [tbes_pkg::TIME_W-1:0] t);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    start       <= 1'b1;
    operation   <= op;
    timer_index <= idx;
    period      <= per;
    one_shot    <= once;
    now         <= t;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic random_cmd();
    int                            r;
    int                            sel;
    logic [tbes_pkg::PERIOD_W-1:0] per;
    r = $urandom_range(99);
    if (r < 35) begin
      sel = $urandom_range(99);
      if (sel < 4)       per = '0;
      else if (sel < 70) per = tbes_pkg::PERIOD_W'($urandom_range(40, 1));
      else if (sel < 88) per = tbes_pkg::PERIOD_W'($urandom_range(65535, 1));
      else               per = tbes_pkg::PERIOD_W'($urandom);
      send_cmd(tbes_pkg::OP_START, tbes_pkg::IDX_W'($urandom_range(tbes_pkg::NUM_TIMERS - 1)),
               per, 1'($urandom),
               sweep_time + (($urandom_range(3) == 0) ? $urandom_range(20) : 0));
    end else if (r < 45) begin
      send_cmd(tbes_pkg::OP_STOP, tbes_pkg::IDX_W'($urandom_range(tbes_pkg::NUM_TIMERS - 1)),
               tbes_pkg::PERIOD_W'($urandom), 1'($urandom), $urandom);
    end else if (r < 50) begin
      send_cmd(OP_UNKNOWN, tbes_pkg::IDX_W'($urandom), tbes_pkg::PERIOD_W'($urandom),
               1'($urandom), $urandom);
    end else begin
      sel = $urandom_range(99);
      if (sel < 75)      sweep_time = sweep_time + $urandom_range(30);
      else if (sel < 85) sweep_time = sweep_time - $urandom_range(10);
      else if (sel < 95) sweep_time = sweep_time + $urandom;
      else               sweep_time = sweep_time + $urandom_range(100000);
      send_cmd(tbes_pkg::OP_SWEEP, tbes_pkg::IDX_W'($urandom), tbes_pkg::PERIOD_W'($urandom),
               1'($urandom), sweep_time);
    end
  endtask

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_cmd(tbes_pkg::OP_SWEEP, '0, '0, 1'b0, 32'd0);
    send_cmd(tbes_pkg::OP_START, 4'd0, '0, 1'b0, 32'd0);
    send_cmd(tbes_pkg::OP_START, 4'd0, 31'd5, 1'b1, 32'd0);
    send_cmd(tbes_pkg::OP_START, 4'd15, {tbes_pkg::PERIOD_W{1'b1}}, 1'b0, 32'd0);
    send_cmd(tbes_pkg::OP_START, 4'd7, 31'd3, 1'b0, 32'd100);
    send_cmd(tbes_pkg::OP_SWEEP, 4'd15, {tbes_pkg::PERIOD_W{1'b1}}, 1'b1, 32'd10);
    send_cmd(tbes_pkg::OP_SWEEP, '0, '0, 1'b0, 32'd10);
    send_cmd(tbes_pkg::OP_SWEEP, '0, '0, 1'b0, 32'h7fff_ffff);
    send_cmd(tbes_pkg::OP_START, 4'd7, 31'd1, 1'b1, 32'hffff_ffff);
    send_cmd(tbes_pkg::OP_SWEEP, '0, '0, 1'b0, 32'd0);
    send_cmd(tbes_pkg::OP_STOP, 4'd15, '0, 1'b0, 32'd0);
    send_cmd(OP_UNKNOWN, {tbes_pkg::IDX_W{1'b1}}, {tbes_pkg::PERIOD_W{1'b1}}, 1'b1,
             {tbes_pkg::TIME_W{1'b1}});
    send_cmd(tbes_pkg::OP_SWEEP, '0, '0, 1'b0, 32'hffff_ffff);
    for (int i = 0; i < 10; i++)
      send_cmd(tbes_pkg::OP_START, tbes_pkg::IDX_W'(i), 31'd2, 1'(i), 32'h8000_0000);
    send_cmd(tbes_pkg::OP_SWEEP, '0, '0, 1'b0, 32'h8000_0002);
    sweep_time = 32'h8000_0002;

    // hold off until the bank has answered everything
    wait_all_results();

    foreach (idle_by_phase[p]) begin
      idle_pct = idle_by_phase[p];
      repeat (PHASE_ITEMS) random_cmd();
      if (p == 1) wait_all_results();
    end

    idle_pct = 0;
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
